/* rtl/cfcu_pkg.sv */
// Shared types and constants of the central FIR convolution unit.
// No dependencies; the top level takes everything by scoped names.
`default_nettype none

package cfcu_pkg;

	localparam int TAPS        = 32;
	localparam int TAP_IDX_W   = $clog2(TAPS);
	localparam int DATA_W      = 24;
	localparam int FRAC_W      = 22;
	localparam int MAX_SAMPLES = 1024;
	localparam int CNT_W       = $clog2(MAX_SAMPLES) + 1;
	localparam int PROD_W      = 2 * DATA_W;
	localparam int ACC_W       = PROD_W + TAP_IDX_W - 1;
	localparam int RND_W       = ACC_W - FRAC_W;
	localparam int SCALE_W     = 8;
	localparam int SCALED_W    = RND_W + SCALE_W + 1;
	localparam int LEN_W       = 5;

	// configuration register indexes
	typedef enum logic {
		REG_KERNEL_LENGTH = 1'b0,
		REG_SCALE         = 1'b1
	} reg_idx_t;

	// input item kinds, carried in tuser
	typedef enum logic {
		OP_TAP    = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_EMIT,
		ST_AFTER
	} state_t;

	// strobes from the sequencer to the datapath
	typedef struct packed {
		logic load_sample;
		logic tap_write;
		logic start_mac;
		logic mac_issue;
		logic do_scale;
		logic do_emit;
		logic flush_shift;
		logic clear;
	} ctrl_t;

endpackage

`default_nettype wire

/* rtl/central_fir_convolution_unit.sv */
// Central FIR convolution unit: top level with sequencer, shared MAC and output register.
// Depends on cfcu_pkg for types and constants.
`default_nettype none

// Same-length FIR convolution of a spectrum with a stored kernel of up to 31 taps.
// A request on the input stream either writes one Q1.22 kernel tap (tuser low)
// or pushes one 24-bit sample (tuser high). All multiply-accumulates of one output run in
// turn through a single 24x24 multiplier followed by one accumulator, and the input stays
// not ready meanwhile. A sample that yields an output keeps the unit busy through check,
// one MAC issue per tap, drain, scale, emit and wrap-up, the emit waiting as long as the
// output register is not free; the next request is then taken back in idle. A sample that
// yields nothing passes only through check and wrap-up. The sample that carries tlast (or
// the 1024th of a spectrum) also flushes the remaining outputs: each flush step shifts one
// zero in and may release one more output through the same steps, so with 31 taps that
// sample can hold the input for up to 16 passes. The final output of a spectrum carries
// tlast, after which the window and counters are cleared. Results wait in an output
// register, so the next request can be taken while the previous result is still pending
// downstream. Kernel taps are undefined until written. Write configuration
// (index 0 kernel_length, index 1 scale) only while idle.
module central_fir_convolution_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [4:0] tap_index, [28:5] value, [31:29] zero
	input  wire logic        s_tuser,   // operation
	input  wire logic        s_tlast,   // last_sample
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [23:0] out_value
	output logic             m_tlast    // last_output
);

	localparam int TI = cfcu_pkg::TAP_IDX_W;
	localparam int DW = cfcu_pkg::DATA_W;
	localparam int CW = cfcu_pkg::CNT_W;

	cfcu_pkg::state_t state_q, state_d;
	cfcu_pkg::ctrl_t  ctrl;

	// configuration
	logic [cfcu_pkg::LEN_W-1:0]   kernel_length_q;
	logic [cfcu_pkg::SCALE_W-1:0] scale_q;

	// storage
	logic signed [DW-1:0] taps_q [cfcu_pkg::TAPS];
	logic signed [DW-1:0] win_q  [cfcu_pkg::TAPS];

	// counters
	logic [CW-1:0] seen_q;
	logic [CW-1:0] next_q;
	logic [CW:0]   newest_q;
	logic          last_q;
	logic [TI-1:0] j_q;

	// datapath
	logic                                  mac_v_s1;
	logic signed [cfcu_pkg::PROD_W-1:0]    prod_s1;
	logic signed [cfcu_pkg::ACC_W-1:0]     acc_q;
	logic signed [cfcu_pkg::SCALED_W-1:0]  scaled_q;
	logic signed [DW-1:0]                  out_value_q;
	logic                                  out_last_q;
	logic                                  out_valid_q;

	// effective length and its halves
	logic [cfcu_pkg::LEN_W-1:0] len;
	logic [cfcu_pkg::LEN_W-1:0] half;
	logic [cfcu_pkg::LEN_W-1:0] lead;
	logic                       s_accept;
	logic                       out_free;
	logic                       pending;
	logic                       emit_cond;
	logic                       is_final;
	logic [TI-1:0]              win_idx;
	logic signed [cfcu_pkg::ACC_W-1:0]    acc_rnd;
	logic signed [cfcu_pkg::RND_W-1:0]    rounded;
	logic signed [cfcu_pkg::SCALED_W-1:0] sat_max;
	logic signed [cfcu_pkg::SCALED_W-1:0] sat_min;
	logic signed [DW-1:0]                 sat_value;
	logic [CW-1:0]                        seen_inc;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == cfcu_pkg::ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tlast  = out_last_q;

	// zero length acts as a single tap
	assign len  = (kernel_length_q == '0) ? cfcu_pkg::LEN_W'(1) : kernel_length_q;
	assign half = len >> 1;
	assign lead = len - cfcu_pkg::LEN_W'(1) - half;

	// an output is due once its lead samples are in the window
	assign pending   = next_q < seen_q;
	assign emit_cond = pending &&
		(newest_q >= ({1'b0, next_q} + (CW+1)'(lead)));
	// the final output of a spectrum leaves no output pending behind it
	assign is_final  = last_q && ((next_q + CW'(1)) == seen_q);
	assign seen_inc  = seen_q + CW'(1);

	// taps are applied unreversed: tap j meets the sample len-1-j slots back
	assign win_idx = TI'(len - cfcu_pkg::LEN_W'(1) - cfcu_pkg::LEN_W'(j_q));

	// round half up, then scale and saturate
	assign acc_rnd = acc_q + (cfcu_pkg::ACC_W'(1) <<< (cfcu_pkg::FRAC_W - 1));
	assign rounded = acc_rnd[cfcu_pkg::ACC_W-1:cfcu_pkg::FRAC_W];
	assign sat_max = cfcu_pkg::SCALED_W'((1 <<< (DW - 1)) - 1);
	assign sat_min = -(cfcu_pkg::SCALED_W'(1) <<< (DW - 1));

	always_comb begin
		if (scaled_q > sat_max) begin
			sat_value = sat_max[DW-1:0];
		end else if (scaled_q < sat_min) begin
			sat_value = sat_min[DW-1:0];
		end else begin
			sat_value = scaled_q[DW-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cfcu_pkg::ST_IDLE: begin
				if (s_accept && (s_tuser == cfcu_pkg::OP_SAMPLE)) begin
					state_d = cfcu_pkg::ST_CHECK;
				end
			end
			cfcu_pkg::ST_CHECK: begin
				state_d = emit_cond ? cfcu_pkg::ST_MAC : cfcu_pkg::ST_AFTER;
			end
			cfcu_pkg::ST_MAC: begin
				if (j_q == TI'(len - cfcu_pkg::LEN_W'(1))) begin
					state_d = cfcu_pkg::ST_DRAIN;
				end
			end
			cfcu_pkg::ST_DRAIN: state_d = cfcu_pkg::ST_SCALE;
			cfcu_pkg::ST_SCALE: state_d = cfcu_pkg::ST_EMIT;
			cfcu_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = cfcu_pkg::ST_AFTER;
				end
			end
			cfcu_pkg::ST_AFTER: begin
				state_d = (last_q && pending) ? cfcu_pkg::ST_CHECK : cfcu_pkg::ST_IDLE;
			end
			default: state_d = cfcu_pkg::ST_IDLE;
		endcase
	end

	// sequencer strobes
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			cfcu_pkg::ST_IDLE: begin
				ctrl.load_sample = s_accept && (s_tuser == cfcu_pkg::OP_SAMPLE);
				ctrl.tap_write   = s_accept && (s_tuser == cfcu_pkg::OP_TAP);
			end
			cfcu_pkg::ST_CHECK: ctrl.start_mac = emit_cond;
			cfcu_pkg::ST_MAC:   ctrl.mac_issue = 1'b1;
			cfcu_pkg::ST_DRAIN: ctrl = '0;
			cfcu_pkg::ST_SCALE: ctrl.do_scale = 1'b1;
			cfcu_pkg::ST_EMIT:  ctrl.do_emit = out_free;
			cfcu_pkg::ST_AFTER: begin
				// keep shifting zeros in until every output is out, then drop the spectrum
				ctrl.flush_shift = last_q && pending;
				ctrl.clear       = last_q && !pending;
			end
			default: ctrl = '0;
		endcase
	end

	// control state, configuration and sample window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= cfcu_pkg::ST_IDLE;
			kernel_length_q <= cfcu_pkg::LEN_W'(1);
			scale_q         <= cfcu_pkg::SCALE_W'(1);
			seen_q          <= '0;
			next_q          <= '0;
			newest_q        <= '0;
			last_q          <= 1'b0;
			j_q             <= '0;
			mac_v_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < cfcu_pkg::TAPS; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			mac_v_s1 <= ctrl.mac_issue;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					cfcu_pkg::REG_KERNEL_LENGTH: kernel_length_q <= cfg_data[cfcu_pkg::LEN_W-1:0];
					cfcu_pkg::REG_SCALE:         scale_q <= cfg_data;
					default:                     scale_q <= scale_q;
				endcase
			end

			if (ctrl.load_sample) begin
				win_q[0] <= s_tdata[TI +: DW];
				for (int i = 1; i < cfcu_pkg::TAPS; i++) begin
					win_q[i] <= win_q[i-1];
				end
				seen_q   <= seen_inc;
				newest_q <= {1'b0, seen_q};
				// an overlong spectrum ends on its last slot
				last_q   <= s_tlast || (seen_inc >= CW'(cfcu_pkg::MAX_SAMPLES));
			end

			if (ctrl.flush_shift) begin
				win_q[0] <= '0;
				for (int i = 1; i < cfcu_pkg::TAPS; i++) begin
					win_q[i] <= win_q[i-1];
				end
				newest_q <= newest_q + (CW+1)'(1);
			end

			if (ctrl.clear) begin
				for (int i = 0; i < cfcu_pkg::TAPS; i++) begin
					win_q[i] <= '0;
				end
				seen_q   <= '0;
				next_q   <= '0;
				newest_q <= '0;
				last_q   <= 1'b0;
			end

			if (ctrl.start_mac) begin
				j_q <= '0;
			end else if (ctrl.mac_issue) begin
				j_q <= j_q + TI'(1);
			end

			if (ctrl.do_emit) begin
				next_q <= next_q + CW'(1);
			end

			// hold the result until taken, refill in the same cycle it drains
			if (ctrl.do_emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: taps, MAC pipeline, scaling and output data
	always_ff @(posedge clk) begin
		if (ctrl.tap_write) begin
			taps_q[s_tdata[TI-1:0]] <= s_tdata[TI +: DW];
		end
		if (ctrl.mac_issue) begin
			prod_s1 <= taps_q[j_q] * win_q[win_idx];
		end
		if (ctrl.start_mac) begin
			acc_q <= '0;
		end else if (mac_v_s1) begin
			acc_q <= acc_q + cfcu_pkg::ACC_W'(prod_s1);
		end
		if (ctrl.do_scale) begin
			scaled_q <= cfcu_pkg::SCALED_W'(rounded) *
				$signed({1'b0, scale_q});
		end
		if (ctrl.do_emit) begin
			out_value_q <= sat_value;
			out_last_q  <= is_final;
		end
	end

	// outputs never overtake the samples that have arrived
	a_next_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		next_q <= seen_q)
		else $error("output index ran past the sample count");

	// the MAC pipeline is empty whenever a new request can be taken
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mac_v_s1)
		else $error("MAC pipeline busy while accepting");

	// the tap counter stays inside the active kernel
	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cfcu_pkg::ST_MAC) |-> (j_q < TI'(len)) || (len == cfcu_pkg::LEN_W'(0)))
		else $error("tap counter outside kernel");

	// each emitted result advances the output index by one
	a_emit_advances: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.do_emit |=> (next_q == $past(next_q) + CW'(1)))
		else $error("output index did not advance on emit");

	// a spectrum is cleared right after its final output is loaded
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.do_emit && is_final) |=> ##1 (seen_q == '0))
		else $error("window not cleared after the final output");

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for central_fir_convolution_unit: streams kernel taps and spectrum
// samples, predicts every convolved output in SystemVerilog and compares it on the output.
// Depends on cfcu_pkg and the unit's RTL only.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfcu_pkg::*;

	localparam int     PERIOD    = 10;
	localparam int     LIMIT     = 400000;
	localparam int     MAX_BURST = 16;
	localparam int     SETTLE    = 64;
	localparam longint OUT_MAX   = (longint'(1) <<< (DATA_W - 1)) - 1;
	localparam longint OUT_MIN   = -(longint'(1) <<< (DATA_W - 1));

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              last;
	} conv_out_t;

	// Shadow of the unit: kernel, sample window, counters and the outputs still owed.
	class same_length_conv;
		int unsigned klen;
		int unsigned scl;
		int          taps[TAPS];
		int          window[TAPS];
		int unsigned seen;
		int unsigned next_out;
		conv_out_t   due_outputs[$];
		int          errors;

		function new();
			klen = 1;
			scl = 1;
			seen = 0;
			next_out = 0;
			errors = 0;
			foreach (taps[i]) begin
				taps[i] = 0;
				window[i] = 0;
			end
		endfunction

		function void write_reg(reg_idx_t idx, logic [7:0] data);
			if (idx == REG_KERNEL_LENGTH) begin
				klen = data[LEN_W-1:0];
			end else begin
				scl = data;
			end
		endfunction

		function int unsigned span();
			return (klen == 0) ? 1 : klen;
		endfunction

		function void shift_in(int s);
			for (int i = TAPS - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = s;
		endfunction

		function int conv_point();
			int unsigned len;
			longint      acc;
			longint      r;
			len = span();
			acc = 0;
			for (int unsigned j = 0; j < len; j++)
				acc += longint'(taps[j]) * longint'(window[len-1-j]);
			// ties go up: add half an LSB, then floor
			r = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
			r = r * longint'(scl);
			if (r > OUT_MAX)
				r = OUT_MAX;
			if (r < OUT_MIN)
				r = OUT_MIN;
			return int'(r);
		endfunction

		function void push_point(inout int unsigned n);
			conv_out_t o;
			if (n < MAX_BURST) begin
				o.value = conv_point();
				o.last = 1'b0;
				due_outputs.push_back(o);
				n++;
			end
		endfunction

		function void take_request(op_t op, logic [TAP_IDX_W-1:0] idx,
				logic [DATA_W-1:0] value, logic last);
			int unsigned len;
			int unsigned lead;
			int unsigned newest;
			int unsigned guard;
			int unsigned n;
			logic        fin;
			if (op == OP_TAP) begin
				taps[idx] = int'($signed(value));
				return;
			end
			len = span();
			lead = len - 1 - len / 2;
			n = 0;
			fin = last;
			shift_in(int'($signed(value)));
			seen++;
			if (seen >= MAX_SAMPLES)
				fin = 1'b1;
			newest = seen - 1;
			if (next_out < seen && newest >= next_out + lead) begin
				push_point(n);
				next_out++;
			end
			if (fin) begin
				guard = 0;
				while (next_out < seen && guard < 4 * TAPS) begin
					shift_in(0);
					newest++;
					guard++;
					if (newest >= next_out + lead) begin
						push_point(n);
						next_out++;
					end
				end
				if (n > 0)
					due_outputs[$].last = 1'b1;
				foreach (window[i])
					window[i] = 0;
				seen = 0;
				next_out = 0;
			end
		endfunction

		function void check_output(logic [DATA_W-1:0] value, logic last);
			conv_out_t e;
			if (due_outputs.size() == 0) begin
				errors++;
				$display("%0t: unexpected output: expected none, actual value %0d last %0b",
					$time, $signed(value), last);
				return;
			end
			e = due_outputs.pop_front();
			if (value !== e.value) begin
				errors++;
				$display("%0t: out_value mismatch: expected %0d, actual %0d",
					$time, $signed(e.value), $signed(value));
			end
			if (last !== e.last) begin
				errors++;
				$display("%0t: last_output mismatch: expected %0b, actual %0b",
					$time, e.last, last);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;     // [4:0] tap_index, [28:5] value, [31:29] zero
	logic        s_tuser = 1'b0;   // operation
	logic        s_tlast = 1'b0;   // last_sample
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;          // [23:0] out_value
	logic        m_tlast;          // last_output

	same_length_conv conv = new();

	// stimulus bookkeeping: idle rates, taps ever written, requests accepted
	int unsigned tx_idle_pct = 21;
	int unsigned rx_idle_pct = 78;
	logic [TAPS-1:0] tap_known = '0;
	int unsigned sent = 0;
	int unsigned cycles = 0;

	central_fir_convolution_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Receiver: stall at random at the current rate; zero rate leaves ready high.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Check every output taken at this edge against the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			conv.check_output(m_tdata, m_tlast);
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Mix of extremes, full-range words and values within +-mag.
	function automatic logic [DATA_W-1:0] rand_value(int unsigned mag);
		int s;
		case ($urandom_range(0, 5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2, 3: return DATA_W'($urandom);
			default: begin
				s = int'($urandom_range(0, 2 * mag)) - int'(mag);
				return s[DATA_W-1:0];
			end
		endcase
	endfunction

	// Offer one request, idling first at the sender's rate; predict once it is taken.
	task automatic push_request(op_t op, logic [TAP_IDX_W-1:0] idx, logic [DATA_W-1:0] value,
			logic last);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tlast <= last;
		s_tdata <= {3'b000, value, idx};
		do @(posedge clk); while (!s_tready);
		conv.take_request(op, idx, value, last);
		if (op == OP_TAP)
			tap_known[idx] = 1'b1;
		sent++;
	endtask

	// Hold the input until every owed output has been delivered.
	task automatic pause_for_outputs();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (conv.due_outputs.size() != 0);
	endtask

	// Quiet the unit fully: samples that yield nothing may still be in the sequencer.
	task automatic settle_outputs();
		pause_for_outputs();
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_reg(reg_idx_t idx, logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		conv.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Write every tap the current length will read that was never written.
	task automatic cover_taps();
		int unsigned len;
		len = conv.span();
		for (int unsigned i = 0; i < len; i++) begin
			if (!tap_known[i])
				push_request(OP_TAP, TAP_IDX_W'(i), rand_value(1 << 20),
					1'($urandom_range(0, 1)));
		end
	endtask

	// Pick a kernel length and scale; the first few settings hit the extremes.
	task automatic new_setting(int unsigned seg);
		int unsigned len_pick[5] = '{31, 1, 0, 2, 30};
		int unsigned scale_pick[4] = '{1, 255, 0, 2};
		int unsigned len;
		int unsigned scl;
		len = (seg < 5) ? len_pick[seg] : $urandom_range(0, 31);
		if (seg < 4) begin
			scl = scale_pick[seg];
		end else begin
			case ($urandom_range(0, 3))
				0: scl = 1;
				1: scl = $urandom_range(2, 4);
				default: scl = $urandom_range(0, 255);
			endcase
		end
		if ($urandom_range(0, 1)) begin
			program_reg(REG_KERNEL_LENGTH, 8'(len));
			program_reg(REG_SCALE, 8'(scl));
		end else begin
			program_reg(REG_SCALE, 8'(scl));
			program_reg(REG_KERNEL_LENGTH, 8'(len));
		end
	endtask

	function automatic int unsigned spectrum_size();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
	endfunction

	// Mostly spectra of random length; some stray tap writes and pauses in between.
	task automatic run_segment(int unsigned n_items);
		int unsigned start;
		int unsigned target;
		int unsigned count;
		int unsigned roll;
		start = sent;
		target = spectrum_size();
		count = 0;
		while (sent - start < n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				push_request(OP_TAP, TAP_IDX_W'($urandom_range(0, 31)), rand_value(1 << 20),
					1'($urandom_range(0, 1)));
			end else if (roll < 11) begin
				pause_for_outputs();
			end else begin
				count++;
				push_request(OP_SAMPLE, TAP_IDX_W'($urandom_range(0, 31)),
					rand_value(1 << 16), count >= target);
				if (count >= target) begin
					count = 0;
					target = spectrum_size();
				end
			end
		end
	endtask

	initial begin
		int unsigned seg;
		int unsigned goal;
		seg = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length 3: extreme taps (one write with tlast, which is ignored), the top
		// tap index, then extreme samples to saturate both ways.
		program_reg(REG_KERNEL_LENGTH, 3);
		program_reg(REG_SCALE, 1);
		push_request(OP_TAP, 0, 24'h800000, 1'b1);
		push_request(OP_TAP, 1, 24'h7FFFFF, 1'b0);
		push_request(OP_TAP, 2, 24'h400000, 1'b0);
		push_request(OP_TAP, 31, 24'hFFFFFF, 1'b0);
		push_request(OP_SAMPLE, 0, 24'h7FFFFF, 1'b0);
		push_request(OP_SAMPLE, 31, 24'h800000, 1'b0);
		push_request(OP_SAMPLE, 5, 24'h000000, 1'b0);
		push_request(OP_SAMPLE, 10, 24'h000001, 1'b0);
		push_request(OP_SAMPLE, 21, 24'hFFFFFF, 1'b1);

		// Zero length acts as one tap; zero scale zeroes the output.
		settle_outputs();
		program_reg(REG_KERNEL_LENGTH, 0);
		program_reg(REG_SCALE, 0);
		push_request(OP_SAMPLE, 0, 24'h7FFFFF, 1'b1);

		// Even length, top scale: half-LSB ties round up for +1 and -1.
		settle_outputs();
		program_reg(REG_KERNEL_LENGTH, 4);
		program_reg(REG_SCALE, 255);
		push_request(OP_TAP, 0, 24'h200000, 1'b0);
		push_request(OP_TAP, 1, 24'h000000, 1'b0);
		push_request(OP_TAP, 2, 24'h000000, 1'b0);
		push_request(OP_TAP, 3, 24'h000000, 1'b0);
		push_request(OP_SAMPLE, 0, 24'h000001, 1'b0);
		push_request(OP_SAMPLE, 0, 24'hFFFFFF, 1'b0);
		push_request(OP_SAMPLE, 0, 24'h000003, 1'b0);
		push_request(OP_SAMPLE, 0, 24'h7FFFFF, 1'b1);

		// Random part in three idle modes. Settings change between segments with a
		// spectrum often still open, so new lengths meet old windows.
		goal = sent;
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 21 : (mode == 1) ? 78 : 0;
			rx_idle_pct = (mode == 0) ? 78 : (mode == 1) ? 21 : 0;
			goal += 35;
			while (sent < goal) begin
				settle_outputs();
				new_setting(seg);
				seg++;
				cover_taps();
				run_segment($urandom_range(10, 20));
			end
		end

		// Drain, give stray outputs time to show, then report.
		settle_outputs();
		if (conv.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
